// ===== sv/sbd_pkg.sv =====
// Shared types and constants for the signed binary to decimal digit converter.
// No dependencies; imported by the controller, datapath and top level.
package sbd_pkg;

	localparam int DIGIT_W = 4;
	localparam int COUNT_W = 5;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_EMIT
	} sbd_state_t;

	typedef struct packed {
		logic load;
		logic shift;
		logic emit;
	} sbd_cmd_t;

	typedef struct packed {
		logic conv_done;
		logic emit_last;
	} sbd_stat_t;

endpackage

// ===== sv/signed_binary_to_decimal_digits.sv =====
// Top level of the signed binary to decimal digit converter.
// Depends on sbd_pkg, sbd_ctrl and sbd_datapath.
//
//   channel   | handshake                 | payload
//   ----------+---------------------------+-----------------------------------
//   request   | start, busy (start&!busy) | value
//   result    | digit_valid (one cycle)   | digit, negative, digit_count, last
//
// A request runs one load step, one shift-and-add-3 step per magnitude bit, then
// one digit per cycle. Busy falls in the cycle that shows the last digit, so the
// next request can enter then. Reset clears the sequencer and the result strobe.
// Results cannot be stalled; each digit is shown for exactly one cycle.
module signed_binary_to_decimal_digits #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [63:0]                 value,
	output logic                        digit_valid,
	output logic [sbd_pkg::DIGIT_W-1:0] digit,
	output logic                        negative,
	output logic [sbd_pkg::COUNT_W-1:0] digit_count,
	output logic                        last
);
	import sbd_pkg::*;

	sbd_cmd_t  cmd;
	sbd_stat_t stat;

	sbd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	sbd_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.value       (value),
		.stat        (stat),
		.digit_valid (digit_valid),
		.digit       (digit),
		.negative    (negative),
		.digit_count (digit_count),
		.last        (last)
	);

endmodule

// ===== sv/sbd_ctrl.sv =====
// Sequencer for the converter: load, one shift per magnitude bit, then one
// digit per cycle. Depends on sbd_pkg.
module sbd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  sbd_pkg::sbd_stat_t stat,
	output sbd_pkg::sbd_cmd_t  cmd,
	output logic              busy
);
	import sbd_pkg::*;

	sbd_state_t state_q;
	sbd_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_CONVERT;
			end
			ST_CONVERT: begin
				if (stat.conv_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (stat.emit_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_CONVERT: cmd.shift = 1'b1;
			ST_EMIT:    cmd.emit  = 1'b1;
			default:    busy      = 1'b0;
		endcase
	end

endmodule

// ===== sv/sbd_datapath.sv =====
// Shift-and-add-3 datapath: magnitude register, BCD digit register, digit
// count tracking and the registered result outputs. Depends on sbd_pkg.
module sbd_datapath #(
	parameter int VALUE_WIDTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sbd_pkg::sbd_cmd_t           cmd,
	input  logic [63:0]                 value,
	output sbd_pkg::sbd_stat_t          stat,
	output logic                        digit_valid,
	output logic [sbd_pkg::DIGIT_W-1:0] digit,
	output logic                        negative,
	output logic [sbd_pkg::COUNT_W-1:0] digit_count,
	output logic                        last
);
	import sbd_pkg::*;

	// Enough digits for the largest magnitude, 2^(VALUE_WIDTH-1).
	localparam int NDIG  = (VALUE_WIDTH * 30103) / 100000 + 1;
	localparam int DIG_IW = $clog2(NDIG);
	localparam int BIT_W = $clog2(VALUE_WIDTH);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic                   neg_q;
	logic [BIT_W-1:0]       bitcnt_q;
	logic [COUNT_W-1:0]     ndig_q;
	logic [COUNT_W-1:0]     emitted_q;
	logic [DIGIT_W-1:0]     bcd_q   [NDIG];
	logic [DIGIT_W-1:0]     adj     [NDIG];
	logic [DIGIT_W-1:0]     bcd_d   [NDIG];

	logic [VALUE_WIDTH-1:0] raw;
	logic [DIGIT_W-1:0]     top_dig;
	logic [COUNT_W-1:0]     emit_idx;

	logic                   valid_q;
	logic [DIGIT_W-1:0]     digit_q;
	logic                   last_q;

	assign raw = value[VALUE_WIDTH-1:0];

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= DIGIT_W'(5)) ? bcd_q[i] + DIGIT_W'(3) : bcd_q[i];
		end
		bcd_d[0] = {adj[0][DIGIT_W-2:0], mag_q[VALUE_WIDTH-1]};
		for (int i = 1; i < NDIG; i++) begin
			bcd_d[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
		end
	end

	// The value at most doubles per step, so the run can only grow by one digit.
	assign top_dig = (ndig_q < COUNT_W'(NDIG)) ? bcd_d[ndig_q[DIG_IW-1:0]] : '0;

	assign emit_idx = ndig_q - COUNT_W'(1) - emitted_q;

	assign stat.conv_done = (bitcnt_q == BIT_W'(VALUE_WIDTH - 1));
	assign stat.emit_last = (emitted_q == ndig_q - COUNT_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitcnt_q  <= '0;
			ndig_q    <= COUNT_W'(1);
			emitted_q <= '0;
			valid_q   <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
			if (cmd.load) begin
				bitcnt_q  <= '0;
				ndig_q    <= COUNT_W'(1);
				emitted_q <= '0;
			end
			if (cmd.shift) begin
				bitcnt_q <= bitcnt_q + BIT_W'(1);
				if (top_dig != '0) ndig_q <= ndig_q + COUNT_W'(1);
			end
			if (cmd.emit) emitted_q <= emitted_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= raw[VALUE_WIDTH-1];
			mag_q <= raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
			for (int i = 0; i < NDIG; i++) bcd_q[i] <= '0;
		end
		if (cmd.shift) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			for (int i = 0; i < NDIG; i++) bcd_q[i] <= bcd_d[i];
		end
		if (cmd.emit) begin
			digit_q <= bcd_q[emit_idx[DIG_IW-1:0]];
			last_q  <= stat.emit_last;
		end
	end

	assign digit_valid = valid_q;
	assign digit       = digit_q;
	assign negative    = neg_q;
	assign digit_count = ndig_q;
	assign last        = last_q;

endmodule

// ===== sv/sbd_check.sv =====
// Port-level checks for the converter, attached to the top level by bind.
// Depends only on the top level's port names.
module sbd_check (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       digit_valid,
	input logic [3:0] digit,
	input logic       negative,
	input logic [4:0] digit_count,
	input logic       last
);

	// An accepted request always raises busy afterwards.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy did not rise after an accepted request");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid |-> digit <= 4'd9 && digit_count != 5'd0)
		else $error("digit or digit count out of range");

	// A run is contiguous: a digit that is not the last is followed at once.
	a_run_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !last |=> digit_valid)
		else $error("gap inside a digit run");

	a_run_fields_hold: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && !last |=> $stable(digit_count) && $stable(negative))
		else $error("sign or digit count changed inside a run");

	// Zero is the only single-digit run that may carry digit 0, and it is positive.
	a_zero_positive: assert property (@(posedge clk) disable iff (!arst_n)
		digit_valid && digit_count == 5'd1 && digit == 4'd0 |-> !negative)
		else $error("negative zero emitted");

endmodule

bind signed_binary_to_decimal_digits sbd_check u_sbd_check (.*);

// ===== tb/signed_binary_to_decimal_digits_tb.sv =====
// Testbench for signed_binary_to_decimal_digits: directed and random requests are checked
// digit by digit against a predictor of the decimal conversion.
// Depends on sbd_pkg and the signed_binary_to_decimal_digits top level.
module signed_binary_to_decimal_digits_tb;
	import sbd_pkg::*;

	localparam int VALUE_WIDTH = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 90;

	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               negative;
		logic [COUNT_W-1:0] digit_count;
		logic               last;
	} digit_result_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [63:0]         value = '0;
	logic                busy;
	logic                digit_valid;
	logic [DIGIT_W-1:0]  digit;
	logic                negative;
	logic [COUNT_W-1:0]  digit_count;
	logic                last;

	digit_result_t pending_digits[$];
	int            error_count = 0;
	int            cycle_count = 0;

	signed_binary_to_decimal_digits #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.value(value),
		.digit_valid(digit_valid),
		.digit(digit),
		.negative(negative),
		.digit_count(digit_count),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Queues the digit run of one accepted request, most significant digit first.
	function automatic void predict_digits(input logic [63:0] raw_in);
		logic [63:0]        mask;
		logic [63:0]        raw;
		logic [63:0]        mag;
		logic               neg;
		logic [DIGIT_W-1:0] digs[20];
		int                 n;
		digit_result_t      r;
		mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
		raw = raw_in & mask;
		neg = raw[VALUE_WIDTH-1];
		mag = neg ? ((~raw + 64'd1) & mask) : raw;
		n = 0;
		if (mag == 64'd0) begin
			digs[0] = '0;
			n = 1;
			neg = 1'b0;
		end else begin
			while (mag != 64'd0) begin
				digs[n] = DIGIT_W'(mag % 64'd10);
				n++;
				mag = mag / 64'd10;
			end
		end
		for (int k = n - 1; k >= 0; k--) begin
			r.digit = digs[k];
			r.negative = neg;
			r.digit_count = COUNT_W'(n);
			r.last = (k == 0);
			pending_digits.push_back(r);
		end
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			error_count++;
		end
	endfunction

	always @(posedge clk) begin
		digit_result_t want;
		if (arst_n) begin
			if (digit_valid) begin
				if (pending_digits.size() == 0) begin
					$display("%0t: digit %0d arrived with no request pending, expected none",
						$time, digit);
					error_count++;
				end else begin
					want = pending_digits.pop_front();
					check_field("digit", want.digit, digit);
					check_field("negative", want.negative, negative);
					check_field("digit_count", want.digit_count, digit_count);
					check_field("last", want.last, last);
				end
			end
			if (start && !busy)
				predict_digits(value);
		end
	end

	// Sends one request; start stays high when the next request follows without a gap.
	task automatic send_request(input logic [63:0] v, input bit allow_gap);
		int gap;
		gap = allow_gap ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			value <= {$urandom, $urandom};
			// The pause counts from the first cycle in which the block could take a request.
			do @(posedge clk); while (busy);
			repeat (gap - 1) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
	endtask

	// Holds off new requests until every queued digit has been seen.
	task automatic wait_for_results();
		start <= 1'b0;
		do @(negedge clk); while (pending_digits.size() != 0);
		@(posedge clk);
	endtask

	// Random magnitude of random bit length, negated half the time.
	function automatic logic [63:0] random_operand();
		logic [63:0] v;
		int          w;
		w = $urandom_range(1, 64);
		v = {$urandom, $urandom} >> (64 - w);
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	task automatic test_edge_values();
		logic [63:0] edge_values[0:19];
		edge_values = '{
			64'd0, 64'd1, -64'd1, 64'd9, -64'd9, 64'd10, -64'd10, 64'd99, 64'd100,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
			64'd1000000000000000000, 64'd999999999999999999, -64'd999999999999999999,
			64'd1234567890123456789, -64'd9876543210, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 64'hFFFF_FFFF_0000_0000
		};
		foreach (edge_values[i])
			send_request(edge_values[i], 1'b1);
	endtask

	task automatic test_random_values();
		for (int i = 0; i < 100; i++) begin
			if (i % 30 == 29)
				wait_for_results();
			if ($urandom_range(0, 4) == 0)
				send_request({$urandom, $urandom}, 1'b1);
			else
				send_request(random_operand(), 1'b1);
		end
	endtask

	task automatic test_back_to_back();
		for (int i = 0; i < 40; i++)
			send_request(random_operand(), 1'b0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_edge_values();
		wait_for_results();
		test_random_values();
		test_back_to_back();
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
